// File: rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// types and operation codes of the generational handle table
// ----------------------------------------------------------------------------
package ght_pkg;

  // slot count, tied to the 10-bit index fields of the items
  localparam int TABLE_DEPTH = 1024;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_ALIVE   = 3'd2,
    OP_ADD     = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_HAS     = 3'd5,
    OP_QSTART  = 3'd6,
    OP_QNEXT   = 3'd7
  } op_t;

  localparam logic CFG_ENTITY_LIMIT = 1'b0;
  localparam logic CFG_COMPONENTS   = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  entity_index;
    logic [31:0] entity_generation;
    logic [5:0]  component_id;
    logic [63:0] required_mask;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  out_index;
    logic [31:0] out_generation;
    logic [10:0] live_entities;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_CLEAR
  } state_t;

endpackage

// File: rtl/generational_handle_table_core.sv
// ----------------------------------------------------------------------------
// generational_handle_table_core
// slot map with generational handles, free stack and component queries
// ----------------------------------------------------------------------------
// Requests enter on req (req_valid/req_stall), one result per request leaves
// on rsp (rsp_valid/rsp_stall). The block takes one request at a time: a
// request is read from the slot memory in ST_READ and written back in
// ST_EXEC, where its result is loaded into the output register; a new
// request is accepted only once the block is back in ST_IDLE. A query next
// walks the slots one at a time, each with a memory read (ST_SCAN_RD) and
// then a compare (ST_SCAN_CHK): its result is loaded when a walked slot
// matches, or when the cursor reaches high_water with no match. The slot
// memory has one read and one write port; handle and component checks go
// through one check unit. After reset a clearing pass writes every slot to
// zero, one slot a cycle, while req_stall is high; configuration writes are
// taken at any time. While the receiver holds rsp_stall the result stays in
// the output register; the next request may still be accepted and read, and
// it waits before its write-back until the register is free.
// ----------------------------------------------------------------------------
module generational_handle_table_core #(
  parameter int MAX_KINDS   = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  ght_pkg::req_t      req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ght_pkg::rsp_t      rsp,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int IW = $clog2(ght_pkg::TABLE_DEPTH);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(ght_pkg::TABLE_DEPTH);

  // slot word: alive, generation, mask
  typedef struct packed {
    logic        alive;
    logic [31:0] gen;
    logic [63:0] mask;
  } slot_t;

  slot_t          slot_mem [ght_pkg::TABLE_DEPTH];
  logic [IW-1:0]  stack_mem [ght_pkg::TABLE_DEPTH];

  ght_pkg::state_t state, state_next;
  ght_pkg::req_t   cur;
  slot_t           rd_slot;
  logic [IW-1:0]   stk_rd;
  logic [10:0]     entity_limit;
  logic [6:0]      components_registered;
  logic [CW-1:0]   free_depth, high_water, live_total, query_cursor;
  logic [63:0]     query_required;
  logic [IW-1:0]   clr_addr;
  logic [CW-1:0]   cap;
  logic [IW-1:0]   slot_addr;

  // memory control
  logic            mem_we;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  slot_t           mem_wdata;
  logic            stk_we;
  logic [IW-1:0]   stk_waddr, stk_raddr;

  logic            rsp_load, out_free;
  ght_pkg::rsp_t   rsp_next;
  logic [CW-1:0]   free_depth_next, high_water_next, live_total_next;
  logic [CW-1:0]   query_cursor_next;
  logic [63:0]     query_required_next;

  logic            hv, kv, comp_bit, from_stack, from_hw;
  logic [63:0]     comp_m;
  logic [31:0]     gen_inc, new_gen;
  logic [IW-1:0]   new_slot;

  assign cap = (entity_limit > 11'(ght_pkg::TABLE_DEPTH)) ? DEPTH_C : CW'(entity_limit);
  assign req_stall = (state != ght_pkg::ST_IDLE);
  // output register can take a new item this cycle
  assign out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    rd_slot <= slot_mem[mem_raddr];
    if (stk_we) stack_mem[stk_waddr] <= cur.entity_index[IW-1:0];
    stk_rd <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entity_limit          <= 11'd1024;
      components_registered <= 7'd0;
    end else if (cfg_we) begin
      if (cfg_index == ght_pkg::CFG_ENTITY_LIMIT) entity_limit <= cfg_data;
      else components_registered <= cfg_data[6:0];
    end
  end

  // shared check unit, on the slot just read
  assign comp_m   = 64'd1 << cur.component_id;
  assign hv       = (CW'(cur.entity_index) < cap) && rd_slot.alive &&
                    (rd_slot.gen == cur.entity_generation);
  assign kv       = (7'(cur.component_id) < components_registered) &&
                    (32'(cur.component_id) < 32'(MAX_KINDS));
  assign comp_bit = (rd_slot.mask & comp_m) != 64'd0;
  assign gen_inc  = rd_slot.gen + 32'd1;
  assign from_stack = (free_depth != '0);
  assign from_hw    = (high_water < cap);
  assign new_slot = from_stack ? stk_rd : high_water[IW-1:0];
  assign new_gen  = (rd_slot.gen == 32'd0) ? 32'd1 : rd_slot.gen;

  always_comb begin
    slot_addr = cur.entity_index[IW-1:0];
    if (ght_pkg::op_t'(cur.req_type) == ght_pkg::OP_CREATE) slot_addr = new_slot;
  end

  always_comb begin
    state_next          = state;
    mem_we              = 1'b0;
    mem_waddr           = slot_addr;
    mem_raddr           = slot_addr;
    mem_wdata           = rd_slot;
    stk_we              = 1'b0;
    stk_waddr           = free_depth[IW-1:0];
    stk_raddr           = IW'(free_depth - CW'(1));
    rsp_load            = 1'b0;
    rsp_next            = '0;
    free_depth_next     = free_depth;
    high_water_next     = high_water;
    live_total_next     = live_total;
    query_cursor_next   = query_cursor;
    query_required_next = query_required;
    case (state)
      ght_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == IW'(ght_pkg::TABLE_DEPTH - 1)) state_next = ght_pkg::ST_IDLE;
      end
      ght_pkg::ST_IDLE: begin
        if (req_valid) state_next = ght_pkg::ST_READ;
      end
      ght_pkg::ST_READ: begin
        // stack top arrives this cycle; slot read issued
        if (ght_pkg::op_t'(cur.req_type) == ght_pkg::OP_QNEXT)
          state_next = ght_pkg::ST_SCAN_RD;
        else
          state_next = ght_pkg::ST_EXEC;
      end
      ght_pkg::ST_EXEC: begin
        // hold with the same slot read until the output register is free
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = ght_pkg::ST_IDLE;
          case (ght_pkg::op_t'(cur.req_type))
            ght_pkg::OP_CREATE: begin
              if (live_total < cap && (from_stack || from_hw)) begin
                mem_we          = 1'b1;
                mem_wdata.alive = 1'b1;
                mem_wdata.gen   = new_gen;
                mem_wdata.mask  = '0;
                live_total_next = live_total + CW'(1);
                if (from_stack) free_depth_next = free_depth - CW'(1);
                else high_water_next = high_water + CW'(1);
                rsp_next.ok             = 1'b1;
                rsp_next.out_index      = 10'(new_slot);
                rsp_next.out_generation = new_gen;
              end
            end
            ght_pkg::OP_DESTROY: begin
              if (hv && free_depth < DEPTH_C) begin
                mem_we          = 1'b1;
                mem_wdata.alive = 1'b0;
                mem_wdata.mask  = '0;
                mem_wdata.gen   = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
                stk_we          = 1'b1;
                free_depth_next = free_depth + CW'(1);
                if (live_total != '0) live_total_next = live_total - CW'(1);
                rsp_next.ok     = 1'b1;
              end
            end
            ght_pkg::OP_ALIVE: rsp_next.ok = hv;
            ght_pkg::OP_ADD: begin
              if (hv && kv) begin
                mem_we         = 1'b1;
                mem_wdata.mask = rd_slot.mask | comp_m;
                rsp_next.ok    = 1'b1;
              end
            end
            ght_pkg::OP_REMOVE: begin
              if (hv && kv && comp_bit) begin
                mem_we         = 1'b1;
                mem_wdata.mask = rd_slot.mask & ~comp_m;
                rsp_next.ok    = 1'b1;
              end
            end
            ght_pkg::OP_HAS: rsp_next.ok = hv && kv && comp_bit;
            ght_pkg::OP_QSTART: begin
              query_required_next = cur.required_mask;
              query_cursor_next   = '0;
              rsp_next.ok         = 1'b1;
            end
            default: ;
          endcase
          rsp_next.live_entities = 11'(live_total_next);
        end
      end
      ght_pkg::ST_SCAN_RD: begin
        mem_raddr = query_cursor[IW-1:0];
        if (query_cursor < high_water) begin
          state_next = ght_pkg::ST_SCAN_CHK;
        end else if (out_free) begin
          rsp_load               = 1'b1;
          rsp_next.live_entities = 11'(live_total);
          state_next             = ght_pkg::ST_IDLE;
        end
      end
      ght_pkg::ST_SCAN_CHK: begin
        // keep reading the cursor slot while a match waits for the output
        mem_raddr = query_cursor[IW-1:0];
        if (rd_slot.alive && (rd_slot.mask & query_required) == query_required) begin
          if (out_free) begin
            query_cursor_next       = query_cursor + CW'(1);
            rsp_load                = 1'b1;
            rsp_next.ok             = 1'b1;
            rsp_next.out_index      = 10'(query_cursor[IW-1:0]);
            rsp_next.out_generation = rd_slot.gen;
            rsp_next.live_entities  = 11'(live_total);
            state_next              = ght_pkg::ST_IDLE;
          end
        end else begin
          query_cursor_next = query_cursor + CW'(1);
          state_next        = ght_pkg::ST_SCAN_RD;
        end
      end
      default: state_next = ght_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ght_pkg::ST_CLEAR;
      clr_addr       <= '0;
      free_depth     <= '0;
      high_water     <= '0;
      live_total     <= '0;
      query_cursor   <= '0;
      query_required <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      clr_addr       <= clr_addr + IW'(1);
      free_depth     <= free_depth_next;
      high_water     <= high_water_next;
      live_total     <= live_total_next;
      query_cursor   <= query_cursor_next;
      query_required <= query_required_next;
      if (rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ght_pkg::ST_IDLE && req_valid) cur <= req;
    if (rsp_load) rsp <= rsp_next;
  end

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    live_total <= cap || live_total <= high_water)
    else $error("live count above slots handed out");

  assert property (@(posedge clk) disable iff (rst)
    free_depth <= high_water)
    else $error("free stack deeper than slots used");

  assert property (@(posedge clk) disable iff (rst)
    query_cursor <= high_water)
    else $error("query cursor past high water");

endmodule
